>>> rtl/smes_pkg.sv
// ----------------------------------------------------------------------------
// smes_pkg: shared constants of the min-edge midpoint shift unit
// Shape size, coordinate width default and the front offset register layout.
// ----------------------------------------------------------------------------
package smes_pkg;

  // Number of corners of one object shape; the merge tree is built for four.
  localparam int unsigned SHAPE_POINTS = 4;

  // Default coordinate width in 1/128 m units.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Front offset register: width and reset value (3.771 m * 128, rounded).
  localparam int unsigned OFFSET_BITS  = 11;
  localparam int unsigned OFFSET_RESET = 483;

endpackage

>>> rtl/smes_mid_lane.sv
// ----------------------------------------------------------------------------
// smes_mid_lane: edge midpoint lane
// Forms the floor half of the sum of two adjacent corner coordinates.
// ----------------------------------------------------------------------------
module smes_mid_lane #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] a_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output logic signed [COORD_BITS-1:0] mid_o
);

  logic signed [COORD_BITS:0] sum;

  // One extra bit holds the full sum; dropping its low bit rounds down.
  assign sum   = {a_i[COORD_BITS-1], a_i} + {b_i[COORD_BITS-1], b_i};
  assign mid_o = sum[COORD_BITS:1];

endmodule

>>> rtl/smes_merge.sv
// ----------------------------------------------------------------------------
// smes_merge: smallest midpoint selection
// Picks the least midpoint by x, then by y, keeping the lowest edge on a tie.
// ----------------------------------------------------------------------------
module smes_merge
  import smes_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] mid_x_i [SHAPE_POINTS],
  input  logic signed [COORD_BITS-1:0] mid_y_i [SHAPE_POINTS],
  output logic signed [COORD_BITS-1:0] sel_x_o,
  output logic signed [COORD_BITS-1:0] sel_y_o
);

  // Strict ordering, so the left (lower edge) candidate wins any full tie.
  function automatic logic lex_less(
    input logic signed [COORD_BITS-1:0] ax,
    input logic signed [COORD_BITS-1:0] ay,
    input logic signed [COORD_BITS-1:0] bx,
    input logic signed [COORD_BITS-1:0] by
  );
    return (ax < bx) || ((ax == bx) && (ay < by));
  endfunction

  logic signed [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                         lo_pick, hi_pick, fin_pick;

  // First level: edges 0/1 and edges 2/3.
  assign lo_pick = lex_less(mid_x_i[1], mid_y_i[1], mid_x_i[0], mid_y_i[0]);
  assign hi_pick = lex_less(mid_x_i[3], mid_y_i[3], mid_x_i[2], mid_y_i[2]);
  assign lo_x    = lo_pick ? mid_x_i[1] : mid_x_i[0];
  assign lo_y    = lo_pick ? mid_y_i[1] : mid_y_i[0];
  assign hi_x    = hi_pick ? mid_x_i[3] : mid_x_i[2];
  assign hi_y    = hi_pick ? mid_y_i[3] : mid_y_i[2];

  // Second level: the upper pair replaces the lower pair only if strictly less.
  assign fin_pick = lex_less(hi_x, hi_y, lo_x, lo_y);
  assign sel_x_o  = fin_pick ? hi_x : lo_x;
  assign sel_y_o  = fin_pick ? hi_y : lo_y;

endmodule

>>> rtl/smes_shift_lane.sv
// ----------------------------------------------------------------------------
// smes_shift_lane: shift and saturate lane
// Computes a plus or minus b, minus an unsigned offset, clipped to range.
// ----------------------------------------------------------------------------
module smes_shift_lane
  import smes_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter bit          SUB_B      = 1'b1
) (
  input  logic signed [COORD_BITS-1:0]  a_i,
  input  logic signed [COORD_BITS-1:0]  b_i,
  input  logic        [OFFSET_BITS-1:0] off_i,
  output logic signed [COORD_BITS-1:0]  res_o,
  output logic                          sat_o
);

  localparam int unsigned XW = COORD_BITS + 2;
  localparam logic signed [XW-1:0] Hi = {3'b000, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [XW-1:0] Lo = ~Hi;

  logic signed [XW-1:0] a_x, b_x, off_x, sum;

  // Two guard bits hold any sum of two coordinates and the offset.
  assign a_x   = {{2{a_i[COORD_BITS-1]}}, a_i};
  assign b_x   = {{2{b_i[COORD_BITS-1]}}, b_i};
  assign off_x = {{(XW-OFFSET_BITS){1'b0}}, off_i};
  assign sum   = SUB_B ? (a_x - b_x - off_x) : (a_x + b_x - off_x);

  // Clip to the signed coordinate range and flag it.
  always_comb begin
    sat_o = 1'b0;
    res_o = sum[COORD_BITS-1:0];
    if (sum > Hi) begin
      sat_o = 1'b1;
      res_o = Hi[COORD_BITS-1:0];
    end else if (sum < Lo) begin
      sat_o = 1'b1;
      res_o = Lo[COORD_BITS-1:0];
    end
  end

endmodule

>>> rtl/shape_min_edge_midpoint_shift_unit.sv
// ----------------------------------------------------------------------------
// shape_min_edge_midpoint_shift_unit: object reference shift to nearest edge
// Rotates a live object's corners, finds the least edge midpoint and moves
// the corners and the distance onto it; dead objects pass through.
// ----------------------------------------------------------------------------
// Usage:
//   An object is taken at a rising edge where start_i is high and busy_o is
//   low. busy_o is always low, so a new object may be issued every cycle.
//   The result appears on the q*_o, new_dist_*_o and saturated_o ports for
//   exactly one cycle, marked by done_o, after the object has passed the
//   stage 1, stage 2 and output registers. The receiver cannot stall; each
//   result transaction is taken in the cycle it is shown, and the next may
//   follow in the next cycle.
//   Pipeline: midpoint lanes (eight adders), merge tree of three ordered
//   compares, then shift lanes (ten adders with clipping) into the output
//   register. There are three register stages; none of them stalls, so
//   throughput is one object per cycle.
//   Configuration: the front offset is written through cfg_valid_i /
//   cfg_data_i; cfg_ready_o is always high. Write it only while no object
//   is in flight.
//   Reset clears the pipeline valid bits and loads the front offset with
//   its default of 483 (3.771 m); no result is issued until an object is
//   taken after reset.
// ----------------------------------------------------------------------------
module shape_min_edge_midpoint_shift_unit
  import smes_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Object input
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         live_i,
  input  logic signed [COORD_BITS-1:0] p0_x_i,
  input  logic signed [COORD_BITS-1:0] p0_y_i,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,
  input  logic signed [COORD_BITS-1:0] dist_x_i,
  input  logic signed [COORD_BITS-1:0] dist_y_i,
  // Configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [OFFSET_BITS-1:0]       cfg_data_i,
  // Result
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] q0_x_o,
  output logic signed [COORD_BITS-1:0] q0_y_o,
  output logic signed [COORD_BITS-1:0] q1_x_o,
  output logic signed [COORD_BITS-1:0] q1_y_o,
  output logic signed [COORD_BITS-1:0] q2_x_o,
  output logic signed [COORD_BITS-1:0] q2_y_o,
  output logic signed [COORD_BITS-1:0] q3_x_o,
  output logic signed [COORD_BITS-1:0] q3_y_o,
  output logic signed [COORD_BITS-1:0] new_dist_x_o,
  output logic signed [COORD_BITS-1:0] new_dist_y_o,
  output logic                         saturated_o
);

  logic                   accept;
  logic [OFFSET_BITS-1:0] offset_q;

  logic signed [COORD_BITS-1:0] px [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] py [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] cx_d [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] cy_d [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] mx_d [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] my_d [SHAPE_POINTS];

  // Stage 1 registers
  logic                         s1_valid_q, s1_live_q;
  logic signed [COORD_BITS-1:0] s1_cx_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] s1_cy_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] s1_mx_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] s1_my_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] s1_dx_q, s1_dy_q;

  // Stage 2 registers
  logic                         s2_valid_q, s2_live_q;
  logic signed [COORD_BITS-1:0] s2_cx_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] s2_cy_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] s2_dx_q, s2_dy_q;
  logic signed [COORD_BITS-1:0] s2_mx_q, s2_my_q;
  logic [OFFSET_BITS-1:0]       s2_off_q;
  logic signed [COORD_BITS-1:0] sel_x, sel_y;

  // Stage 3 lane outputs and output registers
  logic signed [COORD_BITS-1:0] qx_d [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] qy_d [SHAPE_POINTS];
  logic [SHAPE_POINTS-1:0]      satx, saty;
  logic signed [COORD_BITS-1:0] ndx_d, ndy_d;
  logic                         sat_dx, sat_dy;
  logic                         done_q, sat_q;
  logic signed [COORD_BITS-1:0] qx_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] qy_q [SHAPE_POINTS];
  logic signed [COORD_BITS-1:0] ndx_q, ndy_q;

  // The pipeline never stalls, so an object is taken whenever start is high.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Front offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_BITS'(OFFSET_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      offset_q <= cfg_data_i;
    end
  end

  assign px[0] = p0_x_i;
  assign py[0] = p0_y_i;
  assign px[1] = p1_x_i;
  assign py[1] = p1_y_i;
  assign px[2] = p2_x_i;
  assign py[2] = p2_y_i;
  assign px[3] = p3_x_i;
  assign py[3] = p3_y_i;

  // Stage 1: rotate live corners by one and form the edge midpoints.
  for (genvar k = 0; k < SHAPE_POINTS; k++) begin : g_mid
    localparam int unsigned N1 = (k + 1) % SHAPE_POINTS;
    localparam int unsigned N2 = (k + 2) % SHAPE_POINTS;

    assign cx_d[k] = live_i ? px[N1] : px[k];
    assign cy_d[k] = live_i ? py[N1] : py[k];

    smes_mid_lane #(.COORD_BITS(COORD_BITS)) u_mid_x (
      .a_i   (px[N1]),
      .b_i   (px[N2]),
      .mid_o (mx_d[k])
    );

    smes_mid_lane #(.COORD_BITS(COORD_BITS)) u_mid_y (
      .a_i   (py[N1]),
      .b_i   (py[N2]),
      .mid_o (my_d[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_live_q <= live_i;
      s1_dx_q   <= dist_x_i;
      s1_dy_q   <= dist_y_i;
      for (int k = 0; k < SHAPE_POINTS; k++) begin
        s1_cx_q[k] <= cx_d[k];
        s1_cy_q[k] <= cy_d[k];
        s1_mx_q[k] <= mx_d[k];
        s1_my_q[k] <= my_d[k];
      end
    end
  end

  // Stage 2: pick the least midpoint; a dead object gets no shift at all.
  smes_merge #(.COORD_BITS(COORD_BITS)) u_merge (
    .mid_x_i (s1_mx_q),
    .mid_y_i (s1_my_q),
    .sel_x_o (sel_x),
    .sel_y_o (sel_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_live_q <= s1_live_q;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_mx_q   <= s1_live_q ? sel_x : '0;
      s2_my_q   <= s1_live_q ? sel_y : '0;
      s2_off_q  <= s1_live_q ? offset_q : '0;
      for (int k = 0; k < SHAPE_POINTS; k++) begin
        s2_cx_q[k] <= s1_cx_q[k];
        s2_cy_q[k] <= s1_cy_q[k];
      end
    end
  end

  // Stage 3: move corners and distance onto the midpoint, with clipping.
  for (genvar k = 0; k < SHAPE_POINTS; k++) begin : g_shift
    smes_shift_lane #(.COORD_BITS(COORD_BITS), .SUB_B(1'b1)) u_shift_x (
      .a_i   (s2_cx_q[k]),
      .b_i   (s2_mx_q),
      .off_i ('0),
      .res_o (qx_d[k]),
      .sat_o (satx[k])
    );

    smes_shift_lane #(.COORD_BITS(COORD_BITS), .SUB_B(1'b1)) u_shift_y (
      .a_i   (s2_cy_q[k]),
      .b_i   (s2_my_q),
      .off_i ('0),
      .res_o (qy_d[k]),
      .sat_o (saty[k])
    );
  end

  smes_shift_lane #(.COORD_BITS(COORD_BITS), .SUB_B(1'b0)) u_dist_x (
    .a_i   (s2_dx_q),
    .b_i   (s2_mx_q),
    .off_i (s2_off_q),
    .res_o (ndx_d),
    .sat_o (sat_dx)
  );

  smes_shift_lane #(.COORD_BITS(COORD_BITS), .SUB_B(1'b0)) u_dist_y (
    .a_i   (s2_dy_q),
    .b_i   (s2_my_q),
    .off_i ('0),
    .res_o (ndy_d),
    .sat_o (sat_dy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      ndx_q <= ndx_d;
      ndy_q <= ndy_d;
      sat_q <= (|satx) || (|saty) || sat_dx || sat_dy;
      for (int k = 0; k < SHAPE_POINTS; k++) begin
        qx_q[k] <= qx_d[k];
        qy_q[k] <= qy_d[k];
      end
    end
  end

  // Result ports.
  assign done_o       = done_q;
  assign q0_x_o       = qx_q[0];
  assign q0_y_o       = qy_q[0];
  assign q1_x_o       = qx_q[1];
  assign q1_y_o       = qy_q[1];
  assign q2_x_o       = qx_q[2];
  assign q2_y_o       = qy_q[2];
  assign q3_x_o       = qx_q[3];
  assign q3_y_o       = qy_q[3];
  assign new_dist_x_o = ndx_q;
  assign new_dist_y_o = ndy_q;
  assign saturated_o  = sat_q;

  // An accepted object moves one stage per cycle and produces one result.
  a_stage1_to_2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> s2_valid_q)
    else $error("stage 1 item did not advance to stage 2");

  a_stage2_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> done_o)
    else $error("stage 2 item did not produce a result");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_valid_q |=> !done_o)
    else $error("result strobe without an item in flight");

  // A dead object is copied unchanged, so it can never clip.
  a_dead_no_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_live_q) |-> (s2_mx_q == '0 && s2_my_q == '0 && s2_off_q == '0))
    else $error("dead object carries a nonzero shift");

  a_dead_no_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_live_q) |=> !saturated_o)
    else $error("dead object reported saturation");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the min-edge midpoint shift unit
// Drives tracked objects through the command port in bursts with random
// gaps. A directed table comes first: extremes, dead objects, odd sums, ties
// and overflow. Random objects follow over several front offset settings.
// Every result is checked field by field against an in-order predictor.
// ----------------------------------------------------------------------------
module tb;
  import smes_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int NF          = 10;  // coordinate fields of one result
  localparam int HI          = 32767;
  localparam int LO          = -32768;
  localparam int CLK_PERIOD  = 8;
  localparam int PIPE_LAT    = 3;
  localparam int PHASE_ITEMS = 250;
  localparam int DIR_ROWS    = 19;
  localparam int MAX_PRINTS  = 100;

  typedef logic signed [CW-1:0] coord_t;

  // Field order: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, dist_x, dist_y.
  typedef struct {
    logic   live;
    coord_t c [NF];
  } shape_obj_t;

  // Field order: q0_x .. q3_y, new_dist_x, new_dist_y.
  typedef struct {
    coord_t v [NF];
    logic   sat;
  } shift_res_t;

  // One directed row; the expected values count only when typed is set.
  typedef struct {
    bit typed;
    bit live;
    int in_v [NF];
    int ex_v [NF];
    bit ex_sat;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             live_i;
  coord_t           p0_x_i, p0_y_i, p1_x_i, p1_y_i, p2_x_i, p2_y_i, p3_x_i, p3_y_i;
  coord_t           dist_x_i, dist_y_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [OFFSET_BITS-1:0] cfg_data_i;
  logic             done_o;
  coord_t           q0_x_o, q0_y_o, q1_x_o, q1_y_o, q2_x_o, q2_y_o, q3_x_o, q3_y_o;
  coord_t           new_dist_x_o, new_dist_y_o;
  logic             saturated_o;

  shape_min_edge_midpoint_shift_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .live_i       (live_i),
    .p0_x_i       (p0_x_i),
    .p0_y_i       (p0_y_i),
    .p1_x_i       (p1_x_i),
    .p1_y_i       (p1_y_i),
    .p2_x_i       (p2_x_i),
    .p2_y_i       (p2_y_i),
    .p3_x_i       (p3_x_i),
    .p3_y_i       (p3_y_i),
    .dist_x_i     (dist_x_i),
    .dist_y_i     (dist_y_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .q0_x_o       (q0_x_o),
    .q0_y_o       (q0_y_o),
    .q1_x_o       (q1_x_o),
    .q1_y_o       (q1_y_o),
    .q2_x_o       (q2_x_o),
    .q2_y_o       (q2_y_o),
    .q3_x_o       (q3_x_o),
    .q3_y_o       (q3_y_o),
    .new_dist_x_o (new_dist_x_o),
    .new_dist_y_o (new_dist_y_o),
    .saturated_o  (saturated_o)
  );

  // Predictor state and bookkeeping.
  int unsigned front_offset_m;
  shift_res_t  pending_results [$];
  int          n_objects;
  int          n_dead;
  int          n_results;
  int          n_saturated;
  int          n_offsets;
  int          n_mismatch;
  int          burst_left;
  bit          start_up;

  string field_name [NF] = '{"q0_x", "q0_y", "q1_x", "q1_y", "q2_x", "q2_y",
                             "q3_x", "q3_y", "new_dist_x", "new_dist_y"};

  // Directed rows. The first seven carry hand-written results at the reset
  // offset of 483; the rest go through the predictor.
  dir_row_t dir_tab [DIR_ROWS] = '{
    // Dead object at the top of the range passes through.
    '{1'b1, 1'b0, '{HI, HI, HI, HI, HI, HI, HI, HI, HI, HI},
      '{HI, HI, HI, HI, HI, HI, HI, HI, HI, HI}, 1'b0},
    // Dead object at the bottom of the range passes through.
    '{1'b1, 1'b0, '{LO, LO, LO, LO, LO, LO, LO, LO, LO, LO},
      '{LO, LO, LO, LO, LO, LO, LO, LO, LO, LO}, 1'b0},
    // Live object collapsed to the origin: only the offset moves dist_x.
    '{1'b1, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, -483, 0}, 1'b0},
    // All at the top: the distance clips high.
    '{1'b1, 1'b1, '{HI, HI, HI, HI, HI, HI, HI, HI, HI, HI},
      '{0, 0, 0, 0, 0, 0, 0, 0, HI, HI}, 1'b1},
    // All at the bottom: the distance clips low.
    '{1'b1, 1'b1, '{LO, LO, LO, LO, LO, LO, LO, LO, LO, LO},
      '{0, 0, 0, 0, 0, 0, 0, 0, LO, LO}, 1'b1},
    // Dead object with mixed values, no rotation.
    '{1'b1, 1'b0, '{1, -1, LO, HI, 21845, -21846, -21846, 21845, HI, LO},
      '{1, -1, LO, HI, 21845, -21846, -21846, 21845, HI, LO}, 1'b0},
    // Point shape at the origin with a small distance.
    '{1'b1, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 100, -5},
      '{0, 0, 0, 0, 0, 0, 0, 0, -383, -5}, 1'b0},
    // Plain rectangle, rotation visible.
    '{1'b0, 1'b1, '{0, 0, 10, 0, 10, 4, 0, 4, 1000, 0}, '{default: 0}, 1'b0},
    // Same rectangle in the other winding.
    '{1'b0, 1'b1, '{0, 4, 10, 4, 10, 0, 0, 0, -700, 300}, '{default: 0}, 1'b0},
    // Odd corner sums, positive.
    '{1'b0, 1'b1, '{1, 3, 2, 6, 5, -1, -4, 7, 11, -13}, '{default: 0}, 1'b0},
    // Odd corner sums, negative: midpoints round down.
    '{1'b0, 1'b1, '{-1, -3, -2, -6, -5, 1, -7, -9, -11, 13}, '{default: 0}, 1'b0},
    // All midpoints share x; y breaks the tie.
    '{1'b0, 1'b1, '{0, 10, 0, -10, 0, 20, 0, -30, 50, 50}, '{default: 0}, 1'b0},
    // Every edge has the same least midpoint: the first one wins.
    '{1'b0, 1'b1, '{0, 0, 4, 2, 0, 0, 4, 2, 7, 7}, '{default: 0}, 1'b0},
    // Every corner equal.
    '{1'b0, 1'b1, '{5, 5, 5, 5, 5, 5, 5, 5, 0, 0}, '{default: 0}, 1'b0},
    // Opposite extremes: shifted corners clip high.
    '{1'b0, 1'b1, '{HI, HI, LO, LO, HI, LO, LO, HI, 0, 0}, '{default: 0}, 1'b0},
    // Distance x clips low after the offset.
    '{1'b0, 1'b1, '{0, 0, 2, 0, 2, 2, 0, 2, LO, 0}, '{default: 0}, 1'b0},
    // Distance y clips high.
    '{1'b0, 1'b1, '{100, 200, 300, 200, 300, 400, 100, 400, 0, HI}, '{default: 0}, 1'b0},
    // Corner sums beyond the coordinate range.
    '{1'b0, 1'b1, '{HI, HI, HI, HI, HI - 1, LO, LO, HI - 1, 1, -1}, '{default: 0}, 1'b0},
    // Least midpoint on the edge from p2 to p3; alternating bit patterns.
    '{1'b0, 1'b1, '{5, 5, 5, -5, -5, -5, -5, 5, 21845, -21846}, '{default: 0}, 1'b0}
  };

  // Saturate one value to the coordinate range and note any clipping.
  function automatic coord_t clip_coord(longint v, inout bit sat);
    if (v > HI) begin
      sat = 1'b1;
      return coord_t'(HI);
    end
    if (v < LO) begin
      sat = 1'b1;
      return coord_t'(LO);
    end
    return coord_t'(v);
  endfunction

  // Expected result: rotate, pick the least edge midpoint, shift onto it.
  function automatic shift_res_t shift_to_min_edge(shape_obj_t o, int unsigned offset);
    longint     x [4];
    longint     y [4];
    longint     mx, my, ex, ey;
    int         n;
    bit         sat;
    shift_res_t r;
    sat = 1'b0;
    if (!o.live) begin
      r.v = o.c;
      r.sat = 1'b0;
      return r;
    end
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) % 4;
      x[k] = longint'(o.c[2 * n]);
      y[k] = longint'(o.c[2 * n + 1]);
    end
    mx = 0;
    my = 0;
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) % 4;
      // Arithmetic shift of a signed sum is a floor half.
      ex = (x[k] + x[n]) >>> 1;
      ey = (y[k] + y[n]) >>> 1;
      if (k == 0 || ex < mx || (ex == mx && ey < my)) begin
        mx = ex;
        my = ey;
      end
    end
    for (int k = 0; k < 4; k++) begin
      r.v[2 * k]     = clip_coord(x[k] - mx, sat);
      r.v[2 * k + 1] = clip_coord(y[k] - my, sat);
    end
    r.v[8] = clip_coord(longint'(o.c[8]) + mx - longint'(offset), sat);
    r.v[9] = clip_coord(longint'(o.c[9]) + my, sat);
    r.sat = sat;
    return r;
  endfunction

  // Random object: plausible boxes, plus full-range noise, extremes,
  // ties and small odd values.
  function automatic shape_obj_t make_random_object();
    shape_obj_t o;
    int         kind, cx, cy, hl, hw, s;
    int         bx [4];
    int         by [4];
    kind = $urandom_range(0, 9);
    o.live = (kind != 0);
    case (kind)
      0, 1, 2: begin
        for (int k = 0; k < NF; k++) o.c[k] = coord_t'($urandom);
      end
      7: begin
        for (int k = 0; k < NF; k++) begin
          case ($urandom_range(0, 5))
            0: o.c[k] = coord_t'(HI);
            1: o.c[k] = coord_t'(LO);
            2: o.c[k] = coord_t'(HI - 1);
            3: o.c[k] = coord_t'(LO + 1);
            4: o.c[k] = coord_t'(0);
            default: o.c[k] = coord_t'($urandom);
          endcase
        end
      end
      8: begin
        for (int k = 0; k < NF; k++) o.c[k] = coord_t'(int'($urandom_range(0, 3)) - 2);
      end
      9: begin
        for (int k = 0; k < NF; k++) o.c[k] = coord_t'(int'($urandom_range(0, 14)) - 7);
      end
      default: begin
        // Box around a center, ring order starting at a random corner.
        cx = int'($urandom_range(0, 16000)) - 8000;
        cy = int'($urandom_range(0, 16000)) - 8000;
        hl = $urandom_range(0, 600);
        hw = $urandom_range(0, 300);
        bx = '{cx - hl, cx + hl, cx + hl, cx - hl};
        by = '{cy - hw, cy - hw, cy + hw, cy + hw};
        s = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          o.c[2 * k]     = coord_t'(bx[(k + s) % 4]);
          o.c[2 * k + 1] = coord_t'($urandom_range(0, 1) ? by[(k + s) % 4] : by[(7 - k - s) % 4]);
        end
        o.c[8] = coord_t'(int'($urandom_range(0, 24000)) - 12000);
        o.c[9] = coord_t'(int'($urandom_range(0, 24000)) - 12000);
      end
    endcase
    return o;
  endfunction

  // One mismatch: print a line (up to a cap) and count it.
  task automatic report_mismatch(string msg);
    if (n_mismatch < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    n_mismatch++;
  endtask

  // Issue one object and hold it until the block takes it; then either
  // keep start high for the next object or open a gap.
  task automatic send_object(shape_obj_t o, shift_res_t e);
    int gap;
    start_i  <= 1'b1;
    live_i   <= o.live;
    p0_x_i   <= o.c[0];
    p0_y_i   <= o.c[1];
    p1_x_i   <= o.c[2];
    p1_y_i   <= o.c[3];
    p2_x_i   <= o.c[4];
    p2_y_i   <= o.c[5];
    p3_x_i   <= o.c[6];
    p3_y_i   <= o.c[7];
    dist_x_i <= o.c[8];
    dist_y_i <= o.c[9];
    start_up = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(e);
    n_objects++;
    if (!o.live) n_dead++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      start_up = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  // Let the pipeline drain, then write the front offset.
  task automatic write_front_offset(int unsigned value);
    if (start_up) begin
      start_i <= 1'b0;
      start_up = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= OFFSET_BITS'(value);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    front_offset_m = value;
    n_offsets++;
    cfg_valid_i <= 1'b0;
  endtask

  // Clock.
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result checker: each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    shift_res_t got;
    shift_res_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      got.v = '{q0_x_o, q0_y_o, q1_x_o, q1_y_o, q2_x_o, q2_y_o, q3_x_o, q3_y_o,
                new_dist_x_o, new_dist_y_o};
      got.sat = saturated_o;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no object outstanding");
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (want.sat) n_saturated++;
        for (int k = 0; k < NF; k++) begin
          if (got.v[k] !== want.v[k])
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      n_results, field_name[k], got.v[k], want.v[k]));
        end
        if (got.sat !== want.sat)
          report_mismatch($sformatf("result %0d saturated: got %b, expected %b",
                                    n_results, got.sat, want.sat));
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("tb failed");
    $finish;
  end

  // Stimulus.
  initial begin
    shape_obj_t  obj;
    shift_res_t  exp_res;
    int unsigned offsets [7];
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    live_i      <= 1'b0;
    p0_x_i      <= '0;
    p0_y_i      <= '0;
    p1_x_i      <= '0;
    p1_y_i      <= '0;
    p2_x_i      <= '0;
    p2_y_i      <= '0;
    p3_x_i      <= '0;
    p3_y_i      <= '0;
    dist_x_i    <= '0;
    dist_y_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    front_offset_m = OFFSET_RESET;
    n_objects   = 0;
    n_dead      = 0;
    n_results   = 0;
    n_saturated = 0;
    n_offsets   = 1;
    n_mismatch  = 0;
    burst_left  = 0;
    start_up    = 1'b0;
    offsets = '{0, (1 << OFFSET_BITS) - 1, $urandom_range(1, 2046), 1,
                (1 << OFFSET_BITS) - 2, $urandom_range(0, 2047), $urandom_range(0, 2047)};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset offset.
    for (int i = 0; i < DIR_ROWS; i++) begin
      obj.live = dir_tab[i].live;
      for (int k = 0; k < NF; k++) obj.c[k] = coord_t'(dir_tab[i].in_v[k]);
      if (dir_tab[i].typed) begin
        for (int k = 0; k < NF; k++) exp_res.v[k] = coord_t'(dir_tab[i].ex_v[k]);
        exp_res.sat = dir_tab[i].ex_sat;
      end else begin
        exp_res = shift_to_min_edge(obj, front_offset_m);
      end
      send_object(obj, exp_res);
    end

    // Random objects, one phase per front offset setting.
    for (int p = 0; p < 7; p++) begin
      write_front_offset(offsets[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        obj = make_random_object();
        send_object(obj, shift_to_min_edge(obj, front_offset_m));
      end
    end

    if (start_up) start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);

    $display("Checked %0d results from %0d objects (%0d dead, %0d with clipping).",
             n_results, n_objects, n_dead, n_saturated);
    $display("Front offset settings used: %0d, including 0 and 2047; mismatches: %0d.",
             n_offsets, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> shape_min_edge_midpoint_shift_unit.f
rtl/smes_pkg.sv
rtl/smes_mid_lane.sv
rtl/smes_merge.sv
rtl/smes_shift_lane.sv
rtl/shape_min_edge_midpoint_shift_unit.sv
verif/tb.sv
